### hdl/binary_polynomial_multiplier_unit_macros.svh
// ----------------------------------------------------------------------------
// binary polynomial multiplier assertion macros
// shared concurrent assertion forms, clocked on clk_i, gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef BINARY_POLYNOMIAL_MULTIPLIER_UNIT_MACROS_SVH
`define BINARY_POLYNOMIAL_MULTIPLIER_UNIT_MACROS_SVH

// generic form with explicit clock and reset
`define BPM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// default form on the block clock and reset
`define BPM_ASSERT(label, prop, msg) \
  `BPM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### hdl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// types, constants and the carryless word product for the polynomial multiplier
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int NUM_WORDS = 193;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = 9;
  localparam int AW        = $clog2(NUM_WORDS);

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_WORDS - 1);
  localparam logic [IDX_W-1:0] MAX_SUM    = IDX_W'(2 * NUM_WORDS - 2);
  localparam logic [IDX_W-1:0] PROD_WORDS = IDX_W'(2 * NUM_WORDS);
  localparam logic [IDX_W-1:0] OPND_WORDS = IDX_W'(NUM_WORDS);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [IDX_W-1:0]     index;
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] product_word;
    status_e              status;
  } out_item_t;

  // operand pair going into the multiplier stage
  typedef struct packed {
    logic                 valid;
    logic                 hi_sel;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
  } mul_req_t;

  // carryless product of two words, full double width
  function automatic logic [2*WORD_BITS-1:0] clmul(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b
  );
    logic [2*WORD_BITS-1:0] res;
    res = '0;
    for (int s = 0; s < WORD_BITS; s++) begin
      if (a[s]) begin
        res = res ^ ({{WORD_BITS{1'b0}}, b} << s);
      end
    end
    return res;
  endfunction

endpackage

### hdl/bpm_clmul_stage.sv
// ----------------------------------------------------------------------------
// bpm_clmul_stage
// registered carryless word multiplier, hands on the low or high product half
// ----------------------------------------------------------------------------
module bpm_clmul_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpm_pkg::mul_req_t             req_i,
  output logic                          valid_o,
  output logic [bpm_pkg::WORD_BITS-1:0] word_o
);

  logic [2*bpm_pkg::WORD_BITS-1:0] prod;
  logic [bpm_pkg::WORD_BITS-1:0]   word_d, word_q;
  logic                            valid_q;

  always_comb begin
    prod   = bpm_pkg::clmul(req_i.a, req_i.b);
    word_d = req_i.hi_sel ? prod[2*bpm_pkg::WORD_BITS-1:bpm_pkg::WORD_BITS]
                          : prod[bpm_pkg::WORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### hdl/binary_polynomial_multiplier_unit.sv
// ----------------------------------------------------------------------------
// binary_polynomial_multiplier_unit
// carryless product of two 193-word binary polynomials held in word memories
// ----------------------------------------------------------------------------
// load item: result registered in the cycle after accept; a new item each cycle while the output is free
// read item k: one operand pair per cycle through the single multiplier, low
//   halves of pairs summing to k then high halves of pairs summing to k-1
// out-of-range index: result registered in the cycle after accept, status set, word zero
// reset clears control and handshake state; operand memories are not cleared
module binary_polynomial_multiplier_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bpm_pkg::out_item_t out_item_o
);

  `include "binary_polynomial_multiplier_unit_macros.svh"

  localparam int AW    = bpm_pkg::AW;
  localparam int IDX_W = bpm_pkg::IDX_W;
  localparam int WB    = bpm_pkg::WORD_BITS;

  bpm_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] t_q, t_d;
  logic             hi_q, hi_d;
  logic [AW-1:0]    i_q, i_d;
  logic [AW-1:0]    i_end_q, i_end_d;
  logic             rd_v_q, rd_hi_q;
  logic [WB-1:0]    a_rd_q, b_rd_q;
  logic [WB-1:0]    acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  bpm_pkg::out_item_t out_q, out_d;

  logic [WB-1:0] mem_a [bpm_pkg::NUM_WORDS];
  logic [WB-1:0] mem_b [bpm_pkg::NUM_WORDS];

  logic             accept;
  logic             out_free;
  logic             issue;
  logic             last_issue;
  logic             setup_empty;
  logic [IDX_W-1:0] setup_lo, setup_hi;
  logic [IDX_W-1:0] b_addr_full;
  logic             load_ok;
  logic             mul_valid;
  logic [WB-1:0]    mul_word;
  bpm_pkg::mul_req_t mul_req;

  assign out_free    = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign load_ok     = (in_item_i.op == bpm_pkg::OP_LOAD)
                    && (in_item_i.index < bpm_pkg::OPND_WORDS);
  assign last_issue  = (i_q == i_end_q);
  assign b_addr_full = t_q - IDX_W'(i_q);

  // index range of the a word for pairs summing to t
  always_comb begin
    setup_empty = (t_q > bpm_pkg::MAX_SUM);
    setup_lo    = (t_q > bpm_pkg::LAST_IDX) ? (t_q - bpm_pkg::LAST_IDX) : '0;
    setup_hi    = (t_q < bpm_pkg::LAST_IDX) ? t_q : bpm_pkg::LAST_IDX;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpm_pkg::ST_IDLE: begin
        if (accept && (in_item_i.op == bpm_pkg::OP_READ)
            && (in_item_i.index < bpm_pkg::PROD_WORDS)) begin
          state_d = bpm_pkg::ST_SETUP;
        end
      end
      bpm_pkg::ST_SETUP: begin
        if (!setup_empty) begin
          state_d = bpm_pkg::ST_ISSUE;
        end else if (!hi_q && (k_q != '0)) begin
          state_d = bpm_pkg::ST_SETUP;
        end else begin
          state_d = bpm_pkg::ST_DRAIN;
        end
      end
      bpm_pkg::ST_ISSUE: begin
        if (last_issue) begin
          state_d = (!hi_q && (k_q != '0)) ? bpm_pkg::ST_SETUP : bpm_pkg::ST_DRAIN;
        end
      end
      bpm_pkg::ST_DRAIN: begin
        if (!rd_v_q && !mul_valid) begin
          state_d = bpm_pkg::ST_DONE;
        end
      end
      bpm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bpm_pkg::ST_IDLE;
        end
      end
      default: state_d = bpm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o  = 1'b0;
    issue       = 1'b0;
    k_d         = k_q;
    t_d         = t_q;
    hi_d        = hi_q;
    i_d         = i_q;
    i_end_d     = i_end_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (mul_valid) begin
      acc_d = acc_q ^ mul_word;
    end
    case (state_q)
      bpm_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          k_d   = in_item_i.index;
          t_d   = in_item_i.index;
          hi_d  = 1'b0;
          acc_d = '0;
          if (in_item_i.op == bpm_pkg::OP_LOAD) begin
            out_valid_d        = 1'b1;
            out_d.product_word = '0;
            out_d.status       = load_ok ? bpm_pkg::STATUS_OK : bpm_pkg::STATUS_RANGE;
          end else if (in_item_i.index >= bpm_pkg::PROD_WORDS) begin
            out_valid_d        = 1'b1;
            out_d.product_word = '0;
            out_d.status       = bpm_pkg::STATUS_RANGE;
          end
        end
      end
      bpm_pkg::ST_SETUP: begin
        i_d     = setup_lo[AW-1:0];
        i_end_d = setup_hi[AW-1:0];
        if (setup_empty && !hi_q && (k_q != '0)) begin
          hi_d = 1'b1;
          t_d  = k_q - IDX_W'(1);
        end
      end
      bpm_pkg::ST_ISSUE: begin
        issue = 1'b1;
        i_d   = i_q + AW'(1);
        if (last_issue && !hi_q && (k_q != '0)) begin
          hi_d = 1'b1;
          t_d  = k_q - IDX_W'(1);
        end
      end
      bpm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.product_word = acc_q;
          out_d.status       = bpm_pkg::STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
      hi_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_v_q      <= issue;
      hi_q        <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    t_q     <= t_d;
    i_q     <= i_d;
    i_end_q <= i_end_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
    rd_hi_q <= hi_q;
  end

  // operand memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (accept && load_ok) begin
      mem_a[in_item_i.index[AW-1:0]] <= in_item_i.a_word;
      mem_b[in_item_i.index[AW-1:0]] <= in_item_i.b_word;
    end
    a_rd_q <= mem_a[i_q];
    b_rd_q <= mem_b[b_addr_full[AW-1:0]];
  end

  always_comb begin
    mul_req.valid  = rd_v_q;
    mul_req.hi_sel = rd_hi_q;
    mul_req.a      = a_rd_q;
    mul_req.b      = b_rd_q;
  end

  bpm_clmul_stage u_clmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mul_req),
    .valid_o (mul_valid),
    .word_o  (mul_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BPM_ASSERT(a_issue_in_range, (state_q == bpm_pkg::ST_ISSUE) |-> ((IDX_W'(i_q) <= bpm_pkg::LAST_IDX) && (b_addr_full <= bpm_pkg::LAST_IDX)), "operand pair address out of range")
  `BPM_ASSERT(a_idle_pipe_empty, (state_q == bpm_pkg::ST_IDLE) |-> (!rd_v_q && !mul_valid), "multiplier pipeline busy while idle")
  `BPM_ASSERT(a_out_source, $rose(out_valid_q) |-> ($past(state_q == bpm_pkg::ST_DONE) || $past(accept)), "result appeared without a source")
  `BPM_ASSERT(a_range_zero, (out_valid_q && (out_q.status == bpm_pkg::STATUS_RANGE)) |-> (out_q.product_word == '0), "range error carries a nonzero word")

endmodule

### tb/binary_polynomial_multiplier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_polynomial_multiplier_unit_tb
// self-checking bench for the carryless polynomial multiplier: loads both
// operands in full, then walks a table of edge items and random rounds of
// reloads, word patches, product reads and out-of-range noise, with random
// gaps and stalls on both channels, checking every result in order
// ----------------------------------------------------------------------------
module binary_polynomial_multiplier_unit_tb;
  import bpm_pkg::*;

  localparam int PROD_LEN     = 2 * NUM_WORDS;
  localparam int IDX_TOP      = 2 ** IDX_W - 1;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 400;
  localparam int DIR_LEN      = 24;

  typedef enum int {
    PAT_RANDOM,
    PAT_ONE_BIT,
    PAT_ONES,
    PAT_ZERO,
    PAT_ALT,
    PAT_TOP
  } word_pat_e;

  typedef struct packed {
    op_e                  op;
    logic [IDX_W-1:0]     index;
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;
    logic                 typed;
    logic [WORD_BITS-1:0] word;
    status_e              status;
  } stim_row_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] index;
    out_item_t        result;
  } awaited_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // no random gaps or stalls on either side while set
  logic calm = 1'b0;

  logic [WORD_BITS-1:0] a_words [NUM_WORDS];
  logic [WORD_BITS-1:0] b_words [NUM_WORDS];
  awaited_t             awaited_results [$];

  int error_count  = 0;
  int results_seen = 0;
  int valid_items  = 0;
  int n_loads      = 0;
  int n_reads      = 0;
  int n_range      = 0;
  int n_reloads    = 0;

  // typed expectations only where obvious: loads give zero, bad indexes give range
  stim_row_t dir_rows [DIR_LEN] = '{
    '{OP_LOAD, 9'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_OK},
    '{OP_LOAD, 9'd192, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1, 32'h0, STATUS_OK},
    '{OP_LOAD, 9'd1,   32'h0000_0001, 32'h8000_0000, 1'b1, 32'h0, STATUS_OK},
    '{OP_LOAD, 9'd191, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 32'h0, STATUS_OK},
    '{OP_LOAD, 9'd193, 32'hDEAD_BEEF, 32'h1234_5678, 1'b1, 32'h0, STATUS_RANGE},
    '{OP_LOAD, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_RANGE},
    '{OP_LOAD, 9'd256, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, STATUS_RANGE},
    '{OP_READ, 9'd0,   32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd1,   32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd2,   32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd191, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd192, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd193, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd383, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd384, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd385, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd386, 32'h0,         32'h0,         1'b1, 32'h0, STATUS_RANGE},
    '{OP_READ, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_RANGE},
    '{OP_READ, 9'd448, 32'h0,         32'h0,         1'b1, 32'h0, STATUS_RANGE},
    '{OP_LOAD, 9'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, STATUS_OK},
    '{OP_READ, 9'd0,   32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd1,   32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd192, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK},
    '{OP_READ, 9'd385, 32'h0,         32'h0,         1'b0, 32'h0, STATUS_OK}
  };

  binary_polynomial_multiplier_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  // double-width carryless product, shifting x along the set bits of y
  function automatic logic [2*WORD_BITS-1:0] gf2_mul(
    input logic [WORD_BITS-1:0] x,
    input logic [WORD_BITS-1:0] y
  );
    logic [2*WORD_BITS-1:0] acc;
    logic [2*WORD_BITS-1:0] sh;
    acc = '0;
    sh  = {{WORD_BITS{1'b0}}, x};
    for (int n = 0; n < WORD_BITS; n++) begin
      if (y[n]) begin
        acc = acc ^ sh;
      end
      sh = sh << 1;
    end
    return acc;
  endfunction

  function automatic logic [WORD_BITS-1:0] poly_product_word(input int k);
    logic [WORD_BITS-1:0]   acc;
    logic [2*WORD_BITS-1:0] p;
    acc = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (k - i >= 0 && k - i < NUM_WORDS) begin
        p   = gf2_mul(a_words[i], b_words[k-i]);
        acc = acc ^ p[WORD_BITS-1:0];
      end
      // high halves of pairs one position lower carry into word k
      if (k - 1 - i >= 0 && k - 1 - i < NUM_WORDS) begin
        p   = gf2_mul(a_words[i], b_words[k-1-i]);
        acc = acc ^ p[2*WORD_BITS-1:WORD_BITS];
      end
    end
    return acc;
  endfunction

  function automatic out_item_t compute_reply(input in_item_t item);
    out_item_t r;
    r.product_word = '0;
    r.status       = STATUS_OK;
    if (item.op == OP_LOAD) begin
      if (item.index < NUM_WORDS) begin
        a_words[item.index[AW-1:0]] = item.a_word;
        b_words[item.index[AW-1:0]] = item.b_word;
      end else begin
        r.status = STATUS_RANGE;
      end
    end else if (item.index < PROD_LEN) begin
      r.product_word = poly_product_word(int'(item.index));
    end else begin
      r.status = STATUS_RANGE;
    end
    return r;
  endfunction

  function automatic in_item_t pack_item(
    input op_e                  op,
    input int                   idx,
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b
  );
    in_item_t it;
    it.op     = op;
    it.index  = IDX_W'(idx);
    it.a_word = a;
    it.b_word = b;
    return it;
  endfunction

  function automatic logic [WORD_BITS-1:0] pattern_word(input word_pat_e kind);
    logic [WORD_BITS-1:0] w;
    w = WORD_BITS'($urandom);
    case (kind)
      PAT_ONE_BIT: w = WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
      PAT_ONES:    w = '1;
      PAT_ZERO:    w = '0;
      PAT_ALT:     w = $urandom_range(0, 1) ? 32'hAAAA_AAAA : 32'h5555_5555;
      PAT_TOP:     w[WORD_BITS-1] = 1'b1;
      default:     ;
    endcase
    return w;
  endfunction

  function automatic word_pat_e random_pattern();
    return word_pat_e'($urandom_range(PAT_RANDOM, PAT_TOP));
  endfunction

  task automatic send_item(
    input in_item_t  item,
    input logic      typed,
    input out_item_t typed_res
  );
    int       gap;
    awaited_t entry;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entry.op     = item.op;
    entry.index  = item.index;
    entry.result = compute_reply(item);
    if (entry.result.status == STATUS_RANGE) begin
      n_range++;
    end else begin
      valid_items++;
      if (item.op == OP_LOAD) n_loads++;
      else n_reads++;
    end
    if (typed) entry.result = typed_res;
    awaited_results.push_back(entry);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1)) begin
      send_item(pack_item(OP_LOAD, $urandom_range(NUM_WORDS, IDX_TOP),
                          WORD_BITS'($urandom), WORD_BITS'($urandom)), 1'b0, '0);
    end else begin
      send_item(pack_item(OP_READ, $urandom_range(PROD_LEN, IDX_TOP),
                          WORD_BITS'($urandom), WORD_BITS'($urandom)), 1'b0, '0);
    end
  endtask

  task automatic send_read();
    int idx;
    case ($urandom_range(0, 7))
      0:       idx = 0;
      1:       idx = PROD_LEN - 1;
      2:       idx = $urandom_range(NUM_WORDS - 2, NUM_WORDS + 1);
      default: idx = $urandom_range(0, PROD_LEN - 1);
    endcase
    send_item(pack_item(OP_READ, idx, WORD_BITS'($urandom), WORD_BITS'($urandom)),
              1'b0, '0);
  endtask

  // result side: random stalls, two long hold-offs, in-order compare
  initial begin : result_sink
    int       stall;
    awaited_t entry;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (results_seen == 100 || results_seen == 1000) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing awaited: word %h status %0d",
                 $time, out_item.product_word, out_item.status);
        error_count++;
      end else begin
        entry = awaited_results.pop_front();
        if (out_item.product_word !== entry.result.product_word) begin
          $display("%0t: %s index %0d product_word expected %h actual %h", $time,
                   entry.op.name(), entry.index, entry.result.product_word,
                   out_item.product_word);
          error_count++;
        end
        if (out_item.status !== entry.result.status) begin
          $display("%0t: %s index %0d status expected %0d actual %0d", $time,
                   entry.op.name(), entry.index, entry.result.status, out_item.status);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #50ms;
    $display("binary_polynomial_multiplier_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int        order [NUM_WORDS];
    int        tmp;
    int        j;
    int        reads;
    int        patches;
    word_pat_e pa;
    word_pat_e pb;
    out_item_t row_res;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operand word must hold data before any product read
    for (int n = 0; n < NUM_WORDS; n++) begin
      send_item(pack_item(OP_LOAD, n, pattern_word(random_pattern()),
                          pattern_word(random_pattern())), 1'b0, '0);
    end

    for (int r = 0; r < DIR_LEN; r++) begin
      row_res.product_word = dir_rows[r].word;
      row_res.status       = dir_rows[r].status;
      send_item(pack_item(dir_rows[r].op, int'(dir_rows[r].index), dir_rows[r].a_word,
                          dir_rows[r].b_word), dir_rows[r].typed, row_res);
    end

    valid_items = 0;
    while (valid_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // full reload in shuffled or linear order, then a batch of reads
        n_reloads++;
        pa = random_pattern();
        pb = random_pattern();
        for (int n = 0; n < NUM_WORDS; n++) order[n] = n;
        if ($urandom_range(0, 1)) begin
          for (int n = NUM_WORDS - 1; n > 0; n--) begin
            j        = $urandom_range(0, n);
            tmp      = order[n];
            order[n] = order[j];
            order[j] = tmp;
          end
        end
        for (int n = 0; n < NUM_WORDS; n++) begin
          send_item(pack_item(OP_LOAD, order[n], pattern_word(pa), pattern_word(pb)),
                    1'b0, '0);
          if ($urandom_range(0, 40) == 0) send_noise();
        end
        reads = $urandom_range(6, 16);
      end else begin
        patches = $urandom_range(1, 8);
        for (int n = 0; n < patches; n++) begin
          send_item(pack_item(OP_LOAD, $urandom_range(0, NUM_WORDS - 1),
                              pattern_word(random_pattern()),
                              pattern_word(random_pattern())), 1'b0, '0);
        end
        reads = $urandom_range(2, 10);
      end
      for (int n = 0; n < reads; n++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_read();
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d product reads, %0d out-of-range items,",
             n_loads, n_reads, n_range);
    $display("%0d full operand reloads, %0d results checked", n_reloads, results_seen);
    if (error_count == 0) begin
      $display("binary_polynomial_multiplier_unit verification clean");
    end else begin
      $display("binary_polynomial_multiplier_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bpm_pkg.sv
hdl/bpm_clmul_stage.sv
hdl/binary_polynomial_multiplier_unit.sv
tb/binary_polynomial_multiplier_unit_tb.sv
